### rtl/ecpas_pkg.sv
// shared types and codes for the point arithmetic block
package ecpas_pkg;
    localparam logic [1:0] KIND_ADD  = 2'd0;
    localparam logic [1:0] KIND_SUB  = 2'd1;
    localparam logic [1:0] KIND_MUL  = 2'd2;
    localparam logic [1:0] KIND_RSVD = 2'd3;   // no operation, answers infinity

    localparam logic CFG_CURVE_A = 1'b0;
    localparam logic CFG_MODULUS = 1'b1;

    // shared unit operations
    localparam logic [1:0] OP_MOD = 2'd0;   // a mod m, restoring division
    localparam logic [1:0] OP_MUL = 2'd1;   // a*b mod m, shift and add
    localparam logic [1:0] OP_DIV = 2'd2;   // quotient and remainder a / b

    typedef struct packed {
        logic       start;
        logic [1:0] op;
    } t_alu_cmd;
endpackage

### rtl/ecpas_alu.sv
// shared serial modular unit: reduce, multiply mod m, divide, one bit a cycle
module ecpas_alu import ecpas_pkg::*; #(
    parameter int W = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_alu_cmd     i_cmd,
    input  logic [W-1:0] i_a,
    input  logic [W-1:0] i_b,
    input  logic [W-1:0] i_m,
    output logic         o_done,
    output logic [W-1:0] o_res,
    output logic [W-1:0] o_quo
);
    localparam int CW = $clog2(W + 1);

    logic          r_busy, n_busy;
    logic [1:0]    r_op, n_op;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [W-1:0]  r_a, n_a;
    logic [W-1:0]  r_b, n_b;
    logic [W-1:0]  r_m, n_m;
    logic [W-1:0]  r_acc, n_acc;
    logic [W-1:0]  r_quo, n_quo;
    logic          r_done, n_done;
    logic [W:0]    w_sh, w_dbl;
    logic [W:0]    w_sum;

    always_comb begin
        n_busy = r_busy;
        n_op   = r_op;
        n_cnt  = r_cnt;
        n_a    = r_a;
        n_b    = r_b;
        n_m    = r_m;
        n_acc  = r_acc;
        n_quo  = r_quo;
        n_done = 1'b0;
        w_sh   = '0;
        w_dbl  = '0;
        w_sum  = '0;
        if (!r_busy) begin
            if (i_cmd.start) begin
                n_busy = 1'b1;
                n_op   = i_cmd.op;
                n_cnt  = CW'(W);
                n_a    = i_a;
                n_b    = i_b;
                n_m    = (i_cmd.op == OP_DIV) ? i_b : i_m;
                n_acc  = '0;
                n_quo  = '0;
            end
        end else begin
            case (r_op)
                OP_MUL: begin
                    // msb-first: acc = 2acc + bit*a mod m
                    w_dbl = {r_acc, 1'b0};
                    if (w_dbl >= {1'b0, r_m}) w_dbl = w_dbl - {1'b0, r_m};
                    w_sum = w_dbl;
                    if (r_b[W-1]) begin
                        w_sum = w_dbl + {1'b0, r_a};
                        if (w_sum >= {1'b0, r_m}) w_sum = w_sum - {1'b0, r_m};
                    end
                    n_acc = w_sum[W-1:0];
                    n_b   = {r_b[W-2:0], 1'b0};
                end
                default: begin
                    w_sh = {r_acc, r_a[W-1]};
                    n_a  = {r_a[W-2:0], 1'b0};
                    if (w_sh >= {1'b0, r_m}) begin
                        w_sh  = w_sh - {1'b0, r_m};
                        n_quo = {r_quo[W-2:0], 1'b1};
                    end else begin
                        n_quo = {r_quo[W-2:0], 1'b0};
                    end
                    n_acc = w_sh[W-1:0];
                end
            endcase
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_op  <= n_op;
        r_cnt <= n_cnt;
        r_a   <= n_a;
        r_b   <= n_b;
        r_m   <= n_m;
        r_acc <= n_acc;
        r_quo <= n_quo;
    end

    assign o_done = r_done;
    assign o_res  = r_acc;
    assign o_quo  = r_quo;
endmodule

### rtl/ec_point_add_sub_mul_top.sv
// top level: affine point add, subtract and scalar multiply over a prime field
// the shared unit works on W = FIELD_BITS bits; add or subtract reduces the four
//   coordinates, sets up, runs the euclid loop (a divide and a multiply mod m call on
//   the shared unit per step) for the inverse, then works out slope and result
// scalar multiply: up to 2*SCALAR_BITS point ops
// one item in flight, o_stall high until idle; sync active-low reset: curve_a 0, modulus 599
module ec_point_add_sub_mul_top import ecpas_pkg::*; #(
    parameter int FIELD_BITS  = 16,
    parameter int SCALAR_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic                   i_cfg_index,
    input  logic [FIELD_BITS-1:0]  i_cfg_data,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [1:0]             i_kind,
    input  logic [FIELD_BITS-1:0]  i_x1,
    input  logic [FIELD_BITS-1:0]  i_y1,
    input  logic [FIELD_BITS-1:0]  i_x2,
    input  logic [FIELD_BITS-1:0]  i_y2,
    input  logic [SCALAR_BITS-1:0] i_scalar,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [FIELD_BITS-1:0]  o_x_out,
    output logic [FIELD_BITS-1:0]  o_y_out
);
    localparam int W  = FIELD_BITS;
    localparam int SW = (SCALAR_BITS > 1) ? $clog2(SCALAR_BITS) : 1;

    // sequencer states
    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_RED   = 5'd1;   // reduce four coordinates
    localparam logic [4:0] S_DISP  = 5'd2;   // dispatch on kind
    localparam logic [4:0] S_PADD  = 5'd3;   // point add entry: special cases
    localparam logic [4:0] S_DBL0  = 5'd4;   // x*x
    localparam logic [4:0] S_DBL1  = 5'd5;   // 3*x^2
    localparam logic [4:0] S_DBL2  = 5'd6;   // a mod m
    localparam logic [4:0] S_EUC0  = 5'd7;   // euclid: r0 / r1
    localparam logic [4:0] S_EUC1  = 5'd8;   // euclid: shift r, start q*t1 mod m
    localparam logic [4:0] S_EUC2  = 5'd9;   // q*t1 mod m
    localparam logic [4:0] S_SLOPE = 5'd10;  // num * inv
    localparam logic [4:0] S_SQ    = 5'd11;  // s*s
    localparam logic [4:0] S_Y3    = 5'd12;  // s*(x1-x3)
    localparam logic [4:0] S_PEND  = 5'd13;  // point op finished
    localparam logic [4:0] S_OUT   = 5'd14;
    localparam logic [4:0] S_WAIT  = 5'd15;  // waiting for shared unit

    logic [W-1:0] r_curve_a, r_mod;

    logic [4:0]   r_st, n_st;
    logic [4:0]   r_ret, n_ret;       // state after a unit call
    logic [1:0]   r_kind, n_kind;
    logic [W-1:0] r_px, n_px, r_py, n_py;  // first operand / p1 for multiply
    logic [W-1:0] r_qx, n_qx, r_qy, n_qy;  // second operand
    logic [W-1:0] r_bx, n_bx, r_by, n_by;  // p1 kept for multiply
    logic [W-1:0] r_ax, n_ax, r_ay, n_ay;  // accumulator point
    logic [SCALAR_BITS-1:0] r_k, n_k;
    logic [SW-1:0] r_bit, n_bit;
    logic          r_mulphase, n_mulphase; // 0 doubling, 1 adding
    logic [1:0]   r_ridx, n_ridx;
    logic [W-1:0] r_num, n_num;
    logic [W-1:0] r_r0, n_r0, r_r1, n_r1, r_t0, n_t0, r_t1, n_t1;
    logic [W-1:0] r_tmp, n_tmp, r_x3, n_x3;
    logic [W-1:0] r_ox, n_ox, r_oy, n_oy;
    logic         r_ov, n_ov;

    t_alu_cmd     w_cmd;
    logic [W-1:0] w_aa, w_ab;
    logic         w_done;
    logic [W-1:0] w_res, w_quo;

    ecpas_alu #(.W(W)) u_alu (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (w_cmd),
        .i_a    (w_aa),
        .i_b    (w_ab),
        .i_m    (r_mod),
        .o_done (w_done),
        .o_res  (w_res),
        .o_quo  (w_quo)
    );

    // modular helpers on reduced values
    function automatic logic [W-1:0] f_add(input logic [W-1:0] u, input logic [W-1:0] v,
                                           input logic [W-1:0] m);
        logic [W:0] s;
        s = {1'b0, u} + {1'b0, v};
        if (s >= {1'b0, m}) s = s - {1'b0, m};
        return s[W-1:0];
    endfunction

    function automatic logic [W-1:0] f_sub(input logic [W-1:0] u, input logic [W-1:0] v,
                                           input logic [W-1:0] m);
        return (u >= v) ? (u - v) : (m - v + u);
    endfunction

    assign o_stall = (r_st != S_IDLE);
    assign o_valid = r_ov;
    assign o_x_out = r_ox;
    assign o_y_out = r_oy;

    logic w_in_acc;
    assign w_in_acc = i_valid && !o_stall;

    // finish one point op with result (fx,fy)
    logic         w_fin;
    logic [W-1:0] w_fx, w_fy;

    always_comb begin
        n_st = r_st; n_ret = r_ret; n_kind = r_kind;
        n_px = r_px; n_py = r_py; n_qx = r_qx; n_qy = r_qy;
        n_bx = r_bx; n_by = r_by; n_ax = r_ax; n_ay = r_ay;
        n_k = r_k; n_bit = r_bit; n_mulphase = r_mulphase; n_ridx = r_ridx;
        n_num = r_num; n_r0 = r_r0; n_r1 = r_r1; n_t0 = r_t0; n_t1 = r_t1;
        n_tmp = r_tmp; n_x3 = r_x3; n_ox = r_ox; n_oy = r_oy;
        n_ov = r_ov && i_stall;
        w_cmd = '0; w_aa = '0; w_ab = '0;
        w_fin = 1'b0; w_fx = '0; w_fy = '0;

        case (r_st)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_kind = i_kind;
                    n_px = i_x1; n_py = i_y1; n_qx = i_x2; n_qy = i_y2;
                    n_k = i_scalar;
                    n_ridx = 2'd0;
                    if (r_mod < W'(2) || i_kind == KIND_RSVD) begin
                        n_ax = '0; n_ay = '0;
                        n_st = S_OUT;
                    end else begin
                        n_st = S_RED;
                    end
                end
            end
            S_RED: begin
                w_cmd.start = 1'b1;
                w_cmd.op = OP_MOD;
                case (r_ridx)
                    2'd0: w_aa = r_px;
                    2'd1: w_aa = r_py;
                    2'd2: w_aa = r_qx;
                    default: w_aa = r_qy;
                endcase
                n_ret = S_RED;
                n_st = S_WAIT;
            end
            S_WAIT: begin
                if (w_done) begin
                    n_st = r_ret;
                    case (r_ret)
                        S_RED: begin
                            case (r_ridx)
                                2'd0: n_px = w_res;
                                2'd1: n_py = w_res;
                                2'd2: n_qx = w_res;
                                default: n_qy = w_res;
                            endcase
                            n_ridx = r_ridx + 2'd1;
                            n_st = (r_ridx == 2'd3) ? S_DISP : S_RED;
                        end
                        S_DBL1: n_tmp = w_res;
                        S_DBL2: n_tmp = w_res;
                        S_PADD: n_tmp = w_res;  // no unit call returns here
                        S_EUC1: begin n_tmp = w_quo; n_x3 = w_res; end
                        S_EUC2: n_tmp = w_res;
                        S_EUC0: n_tmp = w_res;
                        S_SQ:   n_tmp = w_res;
                        S_Y3:   n_tmp = w_res;
                        S_PEND: n_tmp = w_res;
                        default: n_tmp = w_res;
                    endcase
                end
            end
            S_DISP: begin
                case (r_kind)
                    KIND_SUB: begin
                        if (!(r_qx == '0 && r_qy == '0)) n_qy = f_sub('0, r_qy, r_mod);
                        n_ax = r_px; n_ay = r_py;
                        n_st = S_PADD;
                    end
                    KIND_MUL: begin
                        n_bx = r_px; n_by = r_py;
                        n_ax = '0; n_ay = '0;
                        n_px = '0; n_py = '0; n_qx = '0; n_qy = '0;
                        n_bit = SW'(SCALAR_BITS - 1);
                        n_mulphase = 1'b0;
                        n_st = S_PADD;
                    end
                    default: begin
                        n_ax = r_px; n_ay = r_py;
                        n_st = S_PADD;
                    end
                endcase
            end
            S_PADD: begin
                // p = (px,py), q = (qx,qy)
                if (r_px == '0 && r_py == '0) begin
                    w_fin = 1'b1; w_fx = r_qx; w_fy = r_qy;
                end else if (r_qx == '0 && r_qy == '0) begin
                    w_fin = 1'b1; w_fx = r_px; w_fy = r_py;
                end else if (r_px == r_qx && f_add(r_py, r_qy, r_mod) == '0) begin
                    w_fin = 1'b1;
                end else if (r_px == r_qx && r_py == r_qy) begin
                    n_st = S_DBL0;
                end else begin
                    n_num = f_sub(r_qy, r_py, r_mod);
                    n_r0 = r_mod; n_r1 = f_sub(r_qx, r_px, r_mod);
                    n_t0 = '0; n_t1 = W'(1);
                    n_st = S_EUC0;
                end
            end
            S_DBL0: begin
                w_cmd.start = 1'b1; w_cmd.op = OP_MUL;
                w_aa = r_px; w_ab = r_px;
                n_ret = S_DBL1; n_st = S_WAIT;
            end
            S_DBL1: begin
                // 3*x^2 as x2 + x2 + x2
                n_num = f_add(f_add(r_tmp, r_tmp, r_mod), r_tmp, r_mod);
                w_cmd.start = 1'b1; w_cmd.op = OP_MOD;
                w_aa = r_curve_a;
                n_ret = S_DBL2; n_st = S_WAIT;
            end
            S_DBL2: begin
                n_num = f_add(r_num, r_tmp, r_mod);
                n_r0 = r_mod; n_r1 = f_add(r_py, r_py, r_mod);
                n_t0 = '0; n_t1 = W'(1);
                n_st = S_EUC0;
            end
            S_EUC0: begin
                if (r_r1 == '0) begin
                    if (r_r0 != W'(1)) begin
                        w_fin = 1'b1;
                    end else begin
                        w_cmd.start = 1'b1; w_cmd.op = OP_MUL;
                        w_aa = r_num; w_ab = r_t0;
                        n_ret = S_SLOPE; n_st = S_WAIT;
                    end
                end else begin
                    w_cmd.start = 1'b1; w_cmd.op = OP_DIV;
                    w_aa = r_r0; w_ab = r_r1;
                    n_ret = S_EUC1; n_st = S_WAIT;
                end
            end
            S_EUC1: begin
                // tmp = q, x3 = remainder; q <= m, and q = m multiplies out to zero
                n_r0 = r_r1; n_r1 = r_x3;
                w_cmd.start = 1'b1; w_cmd.op = OP_MUL;
                w_aa = r_tmp; w_ab = r_t1;
                n_ret = S_EUC2; n_st = S_WAIT;
            end
            S_EUC2: begin
                n_t0 = r_t1;
                n_t1 = f_sub(r_t0, r_tmp, r_mod);
                n_st = S_EUC0;
            end
            S_SLOPE: begin
                // tmp = s; keep s in num
                n_num = r_tmp;
                w_cmd.start = 1'b1; w_cmd.op = OP_MUL;
                w_aa = r_tmp; w_ab = r_tmp;
                n_ret = S_SQ; n_st = S_WAIT;
            end
            S_SQ: begin
                n_x3 = f_sub(f_sub(r_tmp, r_px, r_mod), r_qx, r_mod);
                n_st = S_Y3;
                n_ret = S_PEND;
            end
            S_Y3: begin
                w_cmd.start = 1'b1; w_cmd.op = OP_MUL;
                w_aa = r_num; w_ab = f_sub(r_px, r_x3, r_mod);
                n_ret = S_PEND; n_st = S_WAIT;
            end
            S_PEND: begin
                w_fin = 1'b1; w_fx = r_x3; w_fy = f_sub(r_tmp, r_py, r_mod);
            end
            S_OUT: begin
                if (!r_ov || !i_stall) begin
                    n_ov = 1'b1; n_ox = r_ax; n_oy = r_ay;
                    n_st = S_IDLE;
                end
            end
            default: n_st = S_IDLE;
        endcase

        // sequence point ops; multiply walks the scalar msb first
        if (w_fin) begin
            n_ax = w_fx; n_ay = w_fy;
            if (r_kind != KIND_MUL) begin
                n_st = S_OUT;
            end else if (!r_mulphase && r_k[r_bit]) begin
                n_mulphase = 1'b1;
                n_px = w_fx; n_py = w_fy; n_qx = r_bx; n_qy = r_by;
                n_st = S_PADD;
            end else if (r_bit == '0) begin
                n_st = S_OUT;
            end else begin
                n_mulphase = 1'b0;
                n_bit = r_bit - 1'b1;
                n_px = w_fx; n_py = w_fy; n_qx = w_fx; n_qy = w_fy;
                n_st = S_PADD;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st      <= S_IDLE;
            r_ov      <= 1'b0;
            r_curve_a <= '0;
            r_mod     <= W'(599);
        end else begin
            r_st <= n_st;
            r_ov <= n_ov;
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_CURVE_A) r_curve_a <= i_cfg_data;
                else r_mod <= i_cfg_data;
            end
        end
        r_ret <= n_ret; r_kind <= n_kind;
        r_px <= n_px; r_py <= n_py; r_qx <= n_qx; r_qy <= n_qy;
        r_bx <= n_bx; r_by <= n_by; r_ax <= n_ax; r_ay <= n_ay;
        r_k <= n_k; r_bit <= n_bit; r_mulphase <= n_mulphase; r_ridx <= n_ridx;
        r_num <= n_num; r_r0 <= n_r0; r_r1 <= n_r1; r_t0 <= n_t0; r_t1 <= n_t1;
        r_tmp <= n_tmp; r_x3 <= n_x3; r_ox <= n_ox; r_oy <= n_oy;
    end

`ifndef SYNTHESIS
    // result x coordinate stays reduced
    a_out_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ov) |-> (r_ox < r_mod || r_mod < W'(2)))
        else $error("result x not reduced");
    // no new item taken while busy
    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st != S_IDLE) |-> o_stall)
        else $error("stall low while busy");
    // a result appears only when leaving the output state
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ov) |-> $past(r_st) == S_OUT)
        else $error("result without output state");
`endif
endmodule
